FILE: rtl/cgcc_pkg.sv
// ----------------------------------------------------------------------------
// cgcc_pkg: shared types and constants of the corner grid collinearity check
// Point, triple and job layouts, register codes and reset values used by the
// front end, the job queue, the back end and the angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cgcc_pkg;

  // Default sizes of the pattern the block can follow
  localparam int MAX_GRID_WIDTH_DEFAULT  = 16;
  localparam int MAX_GRID_HEIGHT_DEFAULT = 16;

  // Field and counter widths
  localparam int DIM_W       = 5;
  localparam int THR_W       = 16;
  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int ROW_IDX_W   = 5;
  localparam int ROW_IDX_MAX = 31;
  localparam int TOTAL_W     = 9;
  localparam int TOTAL_MAX   = 511;
  localparam int EXPECT_W    = 2 * DIM_W;

  // Register reset values (threshold is 0.993 in Q0.16, rounded down)
  localparam logic [DIM_W-1:0] GRID_WIDTH_RESET    = 5'd11;
  localparam logic [DIM_W-1:0] GRID_HEIGHT_RESET   = 5'd8;
  localparam logic [THR_W-1:0] COS_THRESHOLD_RESET = 16'd65077;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = THR_W;
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GRID_WIDTH    = 2'd0,
    CFG_GRID_HEIGHT   = 2'd1,
    CFG_COS_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  // Difference vectors a = p1 - p0 and b = p2 - p1
  typedef struct packed {
    logic signed [DIFF_W-1:0] ax;
    logic signed [DIFF_W-1:0] ay;
    logic signed [DIFF_W-1:0] bx;
    logic signed [DIFF_W-1:0] by;
  } triple_t;

  typedef struct packed {
    triple_t row_triple;
    triple_t col_triple;
    logic    row_en;
    logic    col_en;
    logic    list_end;
    logic    mismatch;
  } job_t;

  // Side band that travels with one triple through the angle pipeline
  typedef struct packed {
    logic en;
    logic list_end;
    logic mismatch;
  } tag_t;

  typedef enum logic {
    FE_IDLE,
    FE_LOOKUP
  } front_state_t;

  function automatic logic signed [DIFF_W-1:0] coord_diff(
    input logic [COORD_W-1:0] hi,
    input logic [COORD_W-1:0] lo
  );
    return $signed({1'b0, hi}) - $signed({1'b0, lo});
  endfunction

  function automatic triple_t make_triple(
    input point_t p0,
    input point_t p1,
    input point_t p2
  );
    triple_t t;
    t.ax = coord_diff(p1.x, p0.x);
    t.ay = coord_diff(p1.y, p0.y);
    t.bx = coord_diff(p2.x, p1.x);
    t.by = coord_diff(p2.y, p1.y);
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/corner_grid_collinearity_check.sv
// Intake: a new corner is taken only after the job of the last one has entered the
// queue, held off by the column store lookup in the front end, by the angle
// pipeline taking the row and column triples in turn and by a stalled result.
// Reset: synchronous; clears the walk, the queue, the pipeline valids and the
// result valid, and restores the registers. The column store is not cleared.
// ----------------------------------------------------------------------------
// corner_grid_collinearity_check: chessboard corner grid straightness test
// Checks every three consecutive corners along rows and columns for
// collinearity and the corner count against the grid size.
// ----------------------------------------------------------------------------
`default_nettype none

module corner_grid_collinearity_check #(
  parameter int MAX_GRID_WIDTH  = cgcc_pkg::MAX_GRID_WIDTH_DEFAULT,
  parameter int MAX_GRID_HEIGHT = cgcc_pkg::MAX_GRID_HEIGHT_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cgcc_pkg::COORD_W-1:0]     corner_x,
  input  logic [cgcc_pkg::COORD_W-1:0]     corner_y,
  input  logic                             last_corner,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             grid_ok,
  output logic                             count_mismatch,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cgcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cgcc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import cgcc_pkg::*;

  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;
  logic [THR_W-1:0] cos_threshold;

  logic             q_push_valid;
  logic             q_push_ready;
  job_t             q_push_job;
  logic             q_pop_valid;
  logic             q_pop_ready;
  job_t             q_pop_job;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= GRID_WIDTH_RESET;
      grid_height   <= GRID_HEIGHT_RESET;
      cos_threshold <= COS_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:    grid_width    <= cfg_data[DIM_W-1:0];
        CFG_GRID_HEIGHT:   grid_height   <= cfg_data[DIM_W-1:0];
        CFG_COS_THRESHOLD: cos_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  cgcc_front #(
    .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
    .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .corner_x    (corner_x),
    .corner_y    (corner_y),
    .last_corner (last_corner),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .push_valid  (q_push_valid),
    .push_ready  (q_push_ready),
    .push_job    (q_push_job)
  );

  cgcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_job    (q_pop_job)
  );

  cgcc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_pop_valid),
    .job_ready      (q_pop_ready),
    .job            (q_pop_job),
    .cos_threshold  (cos_threshold),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .grid_ok        (grid_ok),
    .count_mismatch (count_mismatch)
  );

  // A mismatched count always fails the grid
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(grid_ok && count_mismatch))
    else $error("grid_ok set together with count_mismatch");

  // The front end takes no corner while it is busy with the column store lookup of the last one
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("corner accepted during column store lookup");

  // Reset leaves no result pending and the intake open
  assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("result or busy intake after reset");

  // A queue push only happens when the front end is busy with a corner
  assert property (@(posedge clk) disable iff (rst)
    (q_push_valid && q_push_ready) |-> !in_ready)
    else $error("job pushed while intake idle");

endmodule

`default_nettype wire

FILE: rtl/cgcc_ram.sv
// ----------------------------------------------------------------------------
// cgcc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cgcc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cgcc_front.sv
// ----------------------------------------------------------------------------
// cgcc_front: corner intake and grid walk
// Accepts one corner, looks up the two stored corners of its column, forms
// the row and column triples and pushes one job per corner into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cgcc_front #(
  parameter int MAX_GRID_WIDTH  = 16,
  parameter int MAX_GRID_HEIGHT = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cgcc_pkg::COORD_W-1:0] corner_x,
  input  logic [cgcc_pkg::COORD_W-1:0] corner_y,
  input  logic                         last_corner,
  input  logic [cgcc_pkg::DIM_W-1:0]   grid_width,
  input  logic [cgcc_pkg::DIM_W-1:0]   grid_height,
  output logic                         push_valid,
  input  logic                         push_ready,
  output cgcc_pkg::job_t               push_job
);

  import cgcc_pkg::*;

  localparam int COL_W   = $clog2(MAX_GRID_WIDTH);
  localparam int STORE_W = 2 * $bits(point_t);

  front_state_t           state;
  front_state_t           state_next;
  point_t                 cur_pt;
  logic                   cur_last;
  point_t                 prev_corner;
  point_t                 prev_prev_corner;
  logic [COL_W-1:0]       column_index;
  logic [ROW_IDX_W-1:0]   row_index;
  logic [TOTAL_W-1:0]     corner_total;

  logic [STORE_W-1:0]     store_rd;
  point_t                 older_pt;
  point_t                 newer_pt;
  logic                   accept;
  logic                   push_fire;

  logic [DIM_W-1:0]       width_eff;
  logic [DIM_W-1:0]       height_eff;
  logic [COL_W:0]         col_inc;
  logic                   wrap;
  logic [ROW_IDX_W-1:0]   row_next;
  logic [TOTAL_W-1:0]     total_next;
  logic [EXPECT_W-1:0]    expected;
  logic                   mismatch;

  assign accept    = in_valid && in_ready;
  assign push_fire = push_valid && push_ready;
  assign {older_pt, newer_pt} = store_rd;

  // Column store: older and newer corner of each column
  cgcc_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_GRID_WIDTH)
  ) u_col_store (
    .clk     (clk),
    .wr_en   (push_fire),
    .wr_addr (column_index),
    .wr_data ({newer_pt, cur_pt}),
    .rd_en   (accept),
    .rd_addr (column_index),
    .rd_data (store_rd)
  );

  // Saturate the grid size to 1..max
  always_comb begin
    if (grid_width == '0) begin
      width_eff = DIM_W'(1);
    end else if (int'(grid_width) > MAX_GRID_WIDTH) begin
      width_eff = DIM_W'(MAX_GRID_WIDTH);
    end else begin
      width_eff = grid_width;
    end
    if (grid_height == '0) begin
      height_eff = DIM_W'(1);
    end else if (int'(grid_height) > MAX_GRID_HEIGHT) begin
      height_eff = DIM_W'(MAX_GRID_HEIGHT);
    end else begin
      height_eff = grid_height;
    end
  end

  // Advance the walk and the count
  always_comb begin
    col_inc    = {1'b0, column_index} + 1'b1;
    wrap       = int'(col_inc) >= int'(width_eff);
    row_next   = row_index;
    if (wrap && row_index != ROW_IDX_W'(ROW_IDX_MAX)) begin
      row_next = row_index + 1'b1;
    end
    total_next = corner_total;
    if (corner_total != TOTAL_W'(TOTAL_MAX)) begin
      total_next = corner_total + 1'b1;
    end
    expected = EXPECT_W'(width_eff) * EXPECT_W'(height_eff);
    mismatch = EXPECT_W'(total_next) != expected;
  end

  // Build the job for the corner in hand
  always_comb begin
    push_job.row_triple = make_triple(prev_prev_corner, prev_corner, cur_pt);
    push_job.col_triple = make_triple(older_pt, newer_pt, cur_pt);
    push_job.row_en     = int'(column_index) >= 2;
    push_job.col_en     = row_index >= ROW_IDX_W'(2);
    push_job.list_end   = cur_last;
    push_job.mismatch   = mismatch;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FE_IDLE: begin
        if (in_valid) begin
          state_next = FE_LOOKUP;
        end
      end
      FE_LOOKUP: begin
        if (push_ready) begin
          state_next = FE_IDLE;
        end
      end
      default: state_next = FE_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    unique case (state)
      FE_IDLE:   in_ready   = 1'b1;
      FE_LOOKUP: push_valid = 1'b1;
      default: begin
        in_ready   = 1'b0;
        push_valid = 1'b0;
      end
    endcase
  end

  // Walk state; drop it all at the end of a list
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= FE_IDLE;
      prev_corner      <= '0;
      prev_prev_corner <= '0;
      column_index     <= '0;
      row_index        <= '0;
      corner_total     <= '0;
    end else begin
      state <= state_next;
      if (push_fire) begin
        if (cur_last) begin
          prev_corner      <= '0;
          prev_prev_corner <= '0;
          column_index     <= '0;
          row_index        <= '0;
          corner_total     <= '0;
        end else begin
          prev_prev_corner <= prev_corner;
          prev_corner      <= cur_pt;
          column_index     <= wrap ? '0 : col_inc[COL_W-1:0];
          row_index        <= row_next;
          corner_total     <= total_next;
        end
      end
    end
  end

  // Hold the accepted corner
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_pt   <= '{y: corner_y, x: corner_x};
      cur_last <= last_corner;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cgcc_queue.sv
// ----------------------------------------------------------------------------
// cgcc_queue: job queue between front and back
// A short first-in first-out buffer that lets each side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cgcc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  cgcc_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cgcc_pkg::job_t pop_job
);

  import cgcc_pkg::*;

  job_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   push_fire;
  logic                   pop_fire;

  assign push_ready = count != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store a beat
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cgcc_angle.sv
// ----------------------------------------------------------------------------
// cgcc_angle: six-stage collinearity test pipeline
// Takes one triple per cycle while adv is high and decides dot^2 * 2^32 <
// thr^2 * |a|^2 * |b|^2 exactly, with 17x17 and 22x32-bit partial products per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cgcc_angle (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       issue_valid,
  input  cgcc_pkg::triple_t          issue_triple,
  input  cgcc_pkg::tag_t             issue_tag,
  input  logic [cgcc_pkg::THR_W-1:0] cos_threshold,
  output logic                       res_valid,
  output cgcc_pkg::tag_t             res_tag,
  output logic                       res_fail
);

  import cgcc_pkg::*;

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld;
  tag_t              tag_pipe [STAGES];

  // Stage 1 combinational products
  logic signed [33:0] p_xx;
  logic signed [33:0] p_yy;
  logic signed [33:0] p_aa_x;
  logic signed [33:0] p_aa_y;
  logic signed [33:0] p_bb_x;
  logic signed [33:0] p_bb_y;
  logic signed [34:0] dot_c;
  logic signed [34:0] na_c;
  logic signed [34:0] nb_c;

  // Stage 1 registers
  logic signed [34:0] dot1;
  logic [32:0]        na1;
  logic [32:0]        nb1;
  logic [31:0]        t2_1;

  // Stage 2
  logic signed [34:0] dot_neg;
  logic [32:0]        mag;
  logic [31:0]        m_hh2;
  logic [32:0]        m_hl2;
  logic [33:0]        m_ll2;
  logic [31:0]        n_hh2;
  logic [32:0]        n_hl2;
  logic [32:0]        n_lh2;
  logic [33:0]        n_ll2;
  logic [31:0]        t2_2;

  // Stage 3
  logic [65:0]        lsq3;
  logic [65:0]        nprod3;
  logic [31:0]        t2_3;

  // Stage 4
  logic [65:0]        lsq4;
  logic [53:0]        r0_4;
  logic [53:0]        r1_4;
  logic [53:0]        r2_4;

  // Stage 5
  logic [65:0]        lsq5;
  logic [97:0]        rhs5;

  // Stage 6
  logic               fail6;

  assign p_xx   = issue_triple.ax * issue_triple.bx;
  assign p_yy   = issue_triple.ay * issue_triple.by;
  assign p_aa_x = issue_triple.ax * issue_triple.ax;
  assign p_aa_y = issue_triple.ay * issue_triple.ay;
  assign p_bb_x = issue_triple.bx * issue_triple.bx;
  assign p_bb_y = issue_triple.by * issue_triple.by;
  assign dot_c  = p_xx + p_yy;
  assign na_c   = p_aa_x + p_aa_y;
  assign nb_c   = p_bb_x + p_bb_y;

  // |dot| stays below 2^33 since |dot| <= |a| * |b|
  assign dot_neg = -dot1;
  assign mag     = dot1[34] ? dot_neg[32:0] : dot1[32:0];

  // Advance valid bits and side band
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], issue_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_pipe[0] <= issue_tag;
      for (int i = 1; i < STAGES; i++) begin
        tag_pipe[i] <= tag_pipe[i-1];
      end
    end
  end

  // Arithmetic stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // dot product, squared lengths, squared threshold
      dot1 <= dot_c;
      na1  <= na_c[32:0];
      nb1  <= nb_c[32:0];
      t2_1 <= cos_threshold * cos_threshold;

      // split the 33-bit operands into 16 and 17-bit halves
      m_hh2 <= mag[32:17] * mag[32:17];
      m_hl2 <= mag[32:17] * mag[16:0];
      m_ll2 <= mag[16:0] * mag[16:0];
      n_hh2 <= na1[32:17] * nb1[32:17];
      n_hl2 <= na1[32:17] * nb1[16:0];
      n_lh2 <= na1[16:0] * nb1[32:17];
      n_ll2 <= na1[16:0] * nb1[16:0];
      t2_2  <= t2_1;

      // sum partial products: dot^2 and |a|^2 * |b|^2
      lsq3   <= (66'(m_hh2) << 34) + (66'(m_hl2) << 18) + 66'(m_ll2);
      nprod3 <= (66'(n_hh2) << 34) + ((66'(n_hl2) + 66'(n_lh2)) << 17) + 66'(n_ll2);
      t2_3   <= t2_2;

      // scale by thr^2 in three 22-bit slices
      lsq4 <= lsq3;
      r0_4 <= nprod3[21:0] * t2_3;
      r1_4 <= nprod3[43:22] * t2_3;
      r2_4 <= nprod3[65:44] * t2_3;

      // assemble the right side
      lsq5 <= lsq4;
      rhs5 <= (98'(r2_4) << 44) + (98'(r1_4) << 22) + 98'(r0_4);

      // compare
      fail6 <= {lsq5, 32'd0} < rhs5;
    end
  end

  assign res_valid = vld[STAGES-1];
  assign res_tag   = tag_pipe[STAGES-1];
  assign res_fail  = fail6;

endmodule

`default_nettype wire

FILE: rtl/cgcc_back.sv
// ----------------------------------------------------------------------------
// cgcc_back: triple dispatch and verdict
// Feeds the row triple and then the column triple of each job to the angle
// pipeline, gathers failures over a list and registers the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cgcc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  cgcc_pkg::job_t             job,
  input  logic [cgcc_pkg::THR_W-1:0] cos_threshold,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       grid_ok,
  output logic                       count_mismatch
);

  import cgcc_pkg::*;

  logic    col_phase;
  logic    adv;
  triple_t issue_triple;
  tag_t    issue_tag;
  logic    res_valid;
  tag_t    res_tag;
  logic    res_fail;
  logic    fail_now;
  logic    verdict;
  logic    angle_fail;

  // Hold the pipeline only while a finished result cannot leave
  assign adv = !(res_valid && res_tag.list_end && out_valid && !out_ready);

  // Row triple first, then column triple; pop after the second
  assign issue_triple       = col_phase ? job.col_triple : job.row_triple;
  assign issue_tag.en       = col_phase ? job.col_en : job.row_en;
  assign issue_tag.list_end = col_phase && job.list_end;
  assign issue_tag.mismatch = job.mismatch;
  assign job_ready          = adv && col_phase;

  cgcc_angle u_angle (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .issue_valid   (job_valid),
    .issue_triple  (issue_triple),
    .issue_tag     (issue_tag),
    .cos_threshold (cos_threshold),
    .res_valid     (res_valid),
    .res_tag       (res_tag),
    .res_fail      (res_fail)
  );

  assign fail_now = res_valid && res_tag.en && res_fail;
  assign verdict  = adv && res_valid && res_tag.list_end;

  // Phase, failure flag and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      col_phase  <= 1'b0;
      angle_fail <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (adv && job_valid) begin
        col_phase <= !col_phase;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (verdict) begin
        out_valid  <= 1'b1;
        angle_fail <= 1'b0;
      end else if (adv && fail_now) begin
        angle_fail <= 1'b1;
      end
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (verdict) begin
      grid_ok        <= !res_tag.mismatch && !(angle_fail || fail_now);
      count_mismatch <= res_tag.mismatch;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_corner_grid_collinearity_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_corner_grid_collinearity_check: self-checking bench for the grid test
// Streams corner lists through the valid/ready input and compares each
// pass/fail verdict against a cycle-free predictor. The predictor tracks the
// row walk, the two column stores and the count. The stimulus starts with a
// few hand-built grids and the register extremes. It then runs random phases
// of near-perfect grids, grids with a wrong length and noise lists, with
// random stalls on both sides.
// ----------------------------------------------------------------------------

module tb_corner_grid_collinearity_check;
  import cgcc_pkg::*;

  localparam int MAXW           = MAX_GRID_WIDTH_DEFAULT;
  localparam int MAXH           = MAX_GRID_HEIGHT_DEFAULT;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int RANDOM_CORNERS = 250;
  localparam int CALM_CORNERS   = 200;   // no stalls past this point
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef struct packed {
    logic ok;
    logic mismatch;
  } verdict_t;

  typedef enum {
    LIST_GRID,
    LIST_MISCOUNT,
    LIST_NOISE
  } list_kind_t;

  // --------------------------------------------------------------------------
  // Verdict scoreboard: walks the grid like the block and queues verdicts
  // --------------------------------------------------------------------------
  class grid_verdict_board;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [31:0]        older [MAXW];
    logic [31:0]        newer [MAXW];
    logic [31:0]        prev1;
    logic [31:0]        prev2;
    int unsigned        col;
    int unsigned        row;
    int unsigned        total;
    bit                 bent_seen;
    verdict_t           pending_verdicts [$];
    int unsigned        errors;
    int unsigned        verdicts;
    int unsigned        straight_grids;
    int unsigned        bent_grids;
    int unsigned        miscounted_grids;

    function new();
      width_reg  = GRID_WIDTH_RESET;
      height_reg = GRID_HEIGHT_RESET;
      thr_reg    = COS_THRESHOLD_RESET;
      foreach (older[k]) begin
        older[k] = '0;
        newer[k] = '0;
      end
      clear_walk();
    endfunction

    function void clear_walk();
      prev1     = '0;
      prev2     = '0;
      col       = 0;
      row       = 0;
      total     = 0;
      bent_seen = 1'b0;
    endfunction

    function void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_WIDTH: begin
          width_reg = data[DIM_W-1:0];
        end
        CFG_GRID_HEIGHT: begin
          height_reg = data[DIM_W-1:0];
        end
        CFG_COS_THRESHOLD: begin
          thr_reg = data[THR_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Saturate the size registers to 1..max
    function int unsigned cols();
      return (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : int'(width_reg));
    endfunction

    function int unsigned rows();
      return (height_reg == 0) ? 1 : ((height_reg > MAXH) ? MAXH : int'(height_reg));
    endfunction

    function int unsigned outstanding();
      return pending_verdicts.size();
    endfunction

    // True when |cos| of the two difference vectors is below the threshold
    function bit is_bent(logic [31:0] p0, logic [31:0] p1, logic [31:0] p2);
      longint       ax;
      longint       ay;
      longint       bx;
      longint       by;
      longint       dot;
      logic [127:0] mag;
      logic [127:0] na;
      logic [127:0] nb;
      logic [127:0] lhs;
      logic [127:0] rhs;
      ax  = longint'(p1[15:0]) - longint'(p0[15:0]);
      ay  = longint'(p1[31:16]) - longint'(p0[31:16]);
      bx  = longint'(p2[15:0]) - longint'(p1[15:0]);
      by  = longint'(p2[31:16]) - longint'(p1[31:16]);
      dot = ax * bx + ay * by;
      mag = (dot < 0) ? -dot : dot;
      na  = ax * ax + ay * ay;
      nb  = bx * bx + by * by;
      lhs = (mag * mag) << 32;
      rhs = na * nb * thr_reg * thr_reg;
      return lhs < rhs;
    endfunction

    // Advance the walk by one accepted corner; queue a verdict on the last one
    function void note_corner(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      logic [31:0] cur;
      verdict_t    v;
      w   = cols();
      h   = rows();
      cur = {y, x};
      c   = col;
      if (c >= 2 && is_bent(prev2, prev1, cur)) bent_seen = 1'b1;
      if (c < MAXW) begin
        if (row >= 2 && is_bent(older[c], newer[c], cur)) bent_seen = 1'b1;
        older[c] = newer[c];
        newer[c] = cur;
      end
      prev2 = prev1;
      prev1 = cur;
      if (total < TOTAL_MAX) total++;
      if (c + 1 >= w) begin
        col = 0;
        if (row < ROW_IDX_MAX) row++;
      end else begin
        col = c + 1;
      end
      if (last) begin
        v.mismatch = (total != w * h);
        v.ok       = !v.mismatch && !bent_seen;
        pending_verdicts = {pending_verdicts, v};
        clear_walk();
      end
    endfunction

    // Compare one result beat with the oldest queued verdict
    function void check_verdict(logic ok, logic mismatch);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected verdict beat: grid_ok=%b count_mismatch=%b",
                   $realtime, ok, mismatch);
        return;
      end
      want = pending_verdicts.pop_front();
      verdicts++;
      if (want.mismatch) miscounted_grids++;
      else if (want.ok) straight_grids++;
      else bent_grids++;
      if (ok !== want.ok || mismatch !== want.mismatch) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] verdict mismatch: expected grid_ok=%b count_mismatch=%b, got %b %b",
                   $realtime, want.ok, want.mismatch, ok, mismatch);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [COORD_W-1:0]     corner_x;
  logic [COORD_W-1:0]     corner_y;
  logic                   last_corner;
  logic                   out_valid;
  logic                   out_ready;
  logic                   grid_ok;
  logic                   count_mismatch;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  grid_verdict_board sb;
  int unsigned       corners_sent = 0;
  int unsigned       lists_sent   = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       tx_idle_pct  = 0;
  int unsigned       rx_idle_pct  = 0;

  corner_grid_collinearity_check u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .corner_x       (corner_x),
    .corner_y       (corner_y),
    .last_corner    (last_corner),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .grid_ok        (grid_ok),
    .count_mismatch (count_mismatch),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hold off the result channel in random bursts
  initial begin : ready_driver
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 10) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check result beats, then watch for a stuck handshake
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_verdict(grid_ok, count_mismatch);
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles, %0d verdicts outstanding",
                 $realtime, quiet_cycles, sb.outstanding());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Idle the sender with the input valid low
  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Present one corner and hold it until the beat is taken
  task automatic send_corner(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic last);
    if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct)
      idle_sender($urandom_range(1, 10));
    @(negedge clk);
    in_valid    <= 1'b1;
    corner_x    <= x;
    corner_y    <= y;
    last_corner <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_corner(x, y, last);
    corners_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every verdict, then let the pipeline empty
  task automatic settle();
    idle_sender(1);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers while idle; junk goes in the unused size bits
  task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [THR_W-1:0] thr);
    logic [CFG_DATA_W-1:0] dw;
    settle();
    dw = CFG_DATA_W'($urandom);
    dw[DIM_W-1:0] = w;
    write_reg(CFG_GRID_WIDTH, dw);
    dw = CFG_DATA_W'($urandom);
    dw[DIM_W-1:0] = h;
    write_reg(CFG_GRID_HEIGHT, dw);
    write_reg(CFG_COS_THRESHOLD, thr);
  endtask

  // Mostly small grids, a few large ones and some out-of-range values
  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return DIM_W'($urandom_range(1, 5));
    if (roll < 90) return DIM_W'($urandom_range(6, 16));
    return DIM_W'($urandom_range(0, 31));
  endfunction

  // Send one list: a sheared grid with jitter, a grid of the wrong length,
  // or random corners of random length
  task automatic send_list(input list_kind_t kind);
    int unsigned w;
    int unsigned n;
    int unsigned jmax;
    int          i;
    int          c;
    int          r;
    int          x0;
    int          y0;
    int          sx;
    int          sy;
    int          shx;
    int          shy;
    int          xv;
    int          yv;
    w = sb.cols();
    n = w * sb.rows();
    case (kind)
      LIST_MISCOUNT: begin
        if (n <= 3 || $urandom_range(0, 1) == 1) n += $urandom_range(1, 3);
        else n -= $urandom_range(1, 3);
      end
      LIST_NOISE: begin
        n = $urandom_range(1, 2 * n + 2);
      end
      default: begin
      end
    endcase
    x0  = $urandom_range(0, 20000);
    y0  = $urandom_range(0, 10000);
    sx  = $urandom_range(16, 2800);
    sy  = $urandom_range(16, 2800);
    shx = $urandom_range(0, 150);
    shy = $urandom_range(0, 150);
    case ($urandom_range(0, 4))
      0: jmax = 0;
      1: jmax = 1;
      2: jmax = 4;
      3: jmax = 16;
      default: jmax = 64;
    endcase
    for (i = 0; i < n; i++) begin
      c = i % w;
      r = i / w;
      if (kind == LIST_NOISE) begin
        xv = $urandom_range(0, 65535);
        yv = $urandom_range(0, 65535);
      end else begin
        xv = x0 + c * sx + r * shx + $urandom_range(0, jmax);
        yv = y0 + r * sy + c * shy + $urandom_range(0, jmax);
      end
      send_corner(xv[COORD_W-1:0], yv[COORD_W-1:0], i == n - 1);
    end
    lists_sent++;
  endtask

  initial begin
    logic [COORD_W-1:0] span_pts [3];
    int unsigned        random_start;
    int unsigned        roll;
    int                 i;
    int                 r;
    int                 c;

    rst         = 1'b1;
    in_valid    = 1'b0;
    corner_x    = '0;
    corner_y    = '0;
    last_corner = 1'b0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_GRID_WIDTH;
    cfg_data    = '0;
    sb          = new();
    span_pts[0] = 16'd0;
    span_pts[1] = 16'd32768;
    span_pts[2] = 16'hFFFF;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Hand-built lists for a 3x3 grid with light stalls
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    configure(5'd3, 5'd3, COS_THRESHOLD_RESET);
    // Straight grid spanning the full coordinate range
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++)
        send_corner(span_pts[c], span_pts[r], r == 2 && c == 2);
    // One corner alone: wrong count
    send_corner(16'hFFFF, 16'hFFFF, 1'b1);
    // Repeated corners: zero-length vectors along rows and columns
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++)
        send_corner((c == 2) ? 16'd3000 : 16'd1000, 16'd500, r == 2 && c == 2);
    lists_sent += 3;

    // Register extremes, including saturated sizes and the threshold ends
    configure(5'd0, 5'd16, 16'hFFFF);
    send_list(LIST_GRID);
    send_list(LIST_MISCOUNT);
    configure(5'd31, 5'd0, 16'd0);
    send_list(LIST_NOISE);
    send_list(LIST_GRID);
    configure(5'd16, 5'd16, COS_THRESHOLD_RESET);
    send_list(LIST_GRID);
    configure(5'd2, 5'd31, 16'd1);
    send_list(LIST_GRID);
    send_list(LIST_NOISE);
    configure(5'd17, 5'd1, 16'hFFFF);
    send_list(LIST_GRID);
    // Overlong column: count and row index both saturate
    configure(5'd1, 5'd1, COS_THRESHOLD_RESET);
    for (i = 0; i < 520; i++)
      send_corner(16'd4000, COORD_W'(i * 100), i == 519);
    lists_sent++;
    // A write to the unused index must change nothing
    settle();
    write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
    send_list(LIST_GRID);

    // Random phases: fresh registers, then a few lists each
    random_start = corners_sent;
    while (corners_sent - random_start < RANDOM_CORNERS) begin
      if (corners_sent - random_start >= CALM_CORNERS) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      roll = $urandom_range(0, 99);
      if (roll < 40) configure(pick_dim(), pick_dim(), THR_W'($urandom_range(64000, 65535)));
      else if (roll < 60) configure(pick_dim(), pick_dim(), COS_THRESHOLD_RESET);
      else if (roll < 80) configure(pick_dim(), pick_dim(), THR_W'($urandom_range(60000, 64000)));
      else configure(pick_dim(), pick_dim(), THR_W'($urandom));
      repeat ($urandom_range(1, 4)) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) send_list(LIST_GRID);
        else if (roll < 85) send_list(LIST_MISCOUNT);
        else send_list(LIST_NOISE);
        // Now and then drain everything before the next list
        if ($urandom_range(0, 4) == 0) settle();
      end
    end

    settle();
    $display("Sent %0d corners in %0d lists; checked %0d verdicts: %0d straight, %0d bent,",
             corners_sent, lists_sent, sb.verdicts, sb.straight_grids, sb.bent_grids);
    $display("%0d with a wrong corner count; %0d failures seen",
             sb.miscounted_grids, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
